// File: design/slotted_page_space_manager_macros.svh
// assertion macros for the slotted page space manager
`ifndef SLOTTED_PAGE_SPACE_MANAGER_MACROS_SVH
`define SLOTTED_PAGE_SPACE_MANAGER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SPSM_CHECK(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPSM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/spsm_pkg.sv
package spsm_pkg;

    // page geometry
    localparam int unsigned PAGE_BYTES   = 4096;
    localparam int unsigned HEADER_BYTES = 36;
    localparam int unsigned ENTRY_BYTES  = 4;
    localparam int unsigned MAX_SLOTS    = 256;
    localparam int unsigned MAX_RECORD   = 2048;

    // widths
    localparam int unsigned FLD_W  = 13;
    localparam int unsigned SLOT_W = 8;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned LIVE_W = 21;

    // request kinds
    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_UPDATE  = 3'd2;
    localparam logic [2:0] KIND_DELETE  = 3'd3;
    localparam logic [2:0] KIND_RESTORE = 3'd4;
    localparam logic [2:0] KIND_COMPACT = 3'd5;
    localparam logic [2:0] KIND_CLEAR   = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARG   = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_CORRUPT   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_MISSING   = 3'd5;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [FLD_W-1:0]  size;
        logic [FLD_W-1:0]  place;
    } spsm_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_number;
        logic [FLD_W-1:0]  payload_offset;
        logic [FLD_W-1:0]  payload_length;
        logic              compacted;
        logic              holes_present;
        logic [FLD_W-1:0]  free_start;
    } spsm_rsp_t;

endpackage

// File: design/slotted_page_space_manager.sv
// read, delete, restore, clear and update in place or by move: lookup, then result
// insert: lookup, dead-slot search over 32-slot chunks, room decision, write, then result
// compaction (compact or update that repacks) walks the slots in use; insert adds a recheck step
// throughput: one transaction at a time, the next is accepted the cycle after the result is loaded
// reset: synchronous active low, empties the page; directory memory is not cleared
`include "slotted_page_space_manager_macros.svh"

module slotted_page_space_manager
    import spsm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  spsm_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output spsm_rsp_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_SCAN, S_DEC, S_CMP, S_CPOST, S_INS, S_RESP
    } state_t;

    localparam logic [FLD_W-1:0]   PAGE_F = FLD_W'(PAGE_BYTES);
    localparam logic [FLD_W:0]     PAGE_W = (FLD_W+1)'(PAGE_BYTES);
    localparam logic [FLD_W-1:0]   MAXR_F = FLD_W'(MAX_RECORD);

    state_t              state_reg;
    spsm_req_t           req_reg;
    logic [MAX_SLOTS-1:0] live_reg;
    logic [CNT_W-1:0]    siu_reg;
    logic [FLD_W-1:0]    fp_reg;
    logic [LIVE_W-1:0]   ltot_reg;
    logic [FLD_W-1:0]    contig_reg;
    logic [FLD_W:0]      room_reg;
    logic [2:0]          st_reg;
    logic [SLOT_W-1:0]   sn_reg;
    logic [FLD_W-1:0]    off_reg;
    logic [FLD_W-1:0]    len_reg;
    logic                cmp_reg;
    logic [CNT_W-1:0]    target_reg;
    logic                reuse_reg;
    logic [2:0]          chunk_reg;
    logic                rep_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                pend_reg;
    logic [SLOT_W-1:0]   pidx_reg;
    logic [FLD_W-1:0]    ptr_reg;
    logic [LIVE_W-1:0]   sum_reg;
    logic [CNT_W-1:0]    last_reg;
    logic                m_valid_reg;
    spsm_rsp_t           m_data_reg;

    // directory memory: place in the upper field, length in the lower
    logic [2*FLD_W-1:0]  mem [MAX_SLOTS];
    logic [2*FLD_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wa;
    logic [2*FLD_W-1:0]  mem_wd;
    logic [SLOT_W-1:0]   mem_ra;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // page figures from the current state
    logic [FLD_W-1:0] dir_end, contig_c, alloc_c, holes_c;
    logic [FLD_W:0]   room_c;
    logic             hole_now;
    always_comb begin
        dir_end  = FLD_W'(HEADER_BYTES) + {2'b00, siu_reg, 2'b00};
        contig_c = (fp_reg < dir_end) ? '0 : fp_reg - dir_end;
        alloc_c  = PAGE_F - fp_reg;
        hole_now = {{(LIVE_W-FLD_W){1'b0}}, alloc_c} > ltot_reg;
        holes_c  = hole_now ? alloc_c - ltot_reg[FLD_W-1:0] : '0;
        room_c   = {1'b0, contig_c} + {1'b0, holes_c};
    end

    // request checks against the entry just read
    logic [FLD_W-1:0] rd_place, rd_bytes, fp_ins, grow;
    logic             found, slot_live, bad_bnd, rst_bad;
    logic             upd_chk, rst_ok, fit_old, fit_ctg, fit_room;
    always_comb begin
        rd_place  = rd_data_reg[2*FLD_W-1:FLD_W];
        rd_bytes  = rd_data_reg[FLD_W-1:0];
        found     = {1'b0, req_reg.slot} < siu_reg;
        slot_live = live_reg[req_reg.slot];
        bad_bnd   = (rd_place < fp_reg) ||
                    (({1'b0, rd_place} + {1'b0, rd_bytes}) > PAGE_W);
        rst_bad   = (req_reg.place < fp_reg) ||
                    (({1'b0, req_reg.place} + {1'b0, req_reg.size}) > PAGE_W);
        fp_ins    = fp_reg - req_reg.size;
        grow      = req_reg.size - rd_bytes;
        upd_chk   = (req_reg.size != '0) && found && slot_live &&
                    (req_reg.size <= MAXR_F) && !bad_bnd;
        rst_ok    = (req_reg.size != '0) && found && !slot_live && !rst_bad;
        fit_old   = req_reg.size <= rd_bytes;
        fit_ctg   = req_reg.size <= contig_reg;
        fit_room  = {1'b0, grow} <= room_reg;
    end

    // dead-slot search over one 32-slot chunk
    logic [31:0]      cand;
    logic [4:0]       enc;
    logic [CNT_W-1:0] next_start;
    logic             scan_end;
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            cand[j] = !live_reg[{chunk_reg, 5'(j)}] &&
                      ({1'b0, chunk_reg, 5'(j)} < siu_reg);
        end
        enc = '0;
        for (int j = 31; j >= 0; j--) begin
            if (cand[j]) begin
                enc = 5'(j);
            end
        end
        next_start = {1'b0, chunk_reg, 5'b0} + CNT_W'(32);
        scan_end   = (chunk_reg == 3'd7) || (next_start >= siu_reg);
    end

    // insert room figures
    logic [FLD_W:0] need;
    always_comb begin
        need = {1'b0, req_reg.size} + (reuse_reg ? '0 : (FLD_W+1)'(ENTRY_BYTES));
    end

    // compaction step on the entry read last cycle
    logic             is_rep, c_live, issue;
    logic [FLD_W-1:0] c_len, c_ptr;
    always_comb begin
        is_rep = rep_reg && (pidx_reg == req_reg.slot);
        c_len  = is_rep ? req_reg.size : rd_bytes;
        c_live = live_reg[pidx_reg] || is_rep;
        c_ptr  = (c_len > ptr_reg) ? '0 : ptr_reg - c_len;
        issue  = rd_idx_reg < siu_reg;
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = req_reg.slot;
        mem_wd = {rd_place, req_reg.size};
        mem_ra = (state_reg == S_IDLE) ? s_data.slot : rd_idx_reg[SLOT_W-1:0];
        unique case (state_reg)
            S_LOOK: begin
                if (req_reg.kind == KIND_UPDATE && upd_chk) begin
                    if (fit_old) begin
                        mem_we = 1'b1;
                    end else if (fit_ctg) begin
                        mem_we = 1'b1;
                        mem_wd = {fp_ins, req_reg.size};
                    end
                end else if (req_reg.kind == KIND_RESTORE && rst_ok) begin
                    mem_we = 1'b1;
                    mem_wd = {req_reg.place, req_reg.size};
                end
            end
            S_CMP: begin
                mem_we = pend_reg && c_live;
                mem_wa = pidx_reg;
                mem_wd = {c_ptr, c_len};
            end
            S_INS: begin
                mem_we = (contig_reg >= need[FLD_W-1:0]) && !need[FLD_W] &&
                         (reuse_reg || siu_reg < CNT_W'(MAX_SLOTS));
                mem_wa = target_reg[SLOT_W-1:0];
                mem_wd = {fp_ins, req_reg.size};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sequencer and page registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            live_reg    <= '0;
            siu_reg     <= '0;
            fp_reg      <= PAGE_F;
            ltot_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg    <= s_data;
                        contig_reg <= contig_c;
                        room_reg   <= room_c;
                        st_reg     <= ST_OK;
                        sn_reg     <= (s_data.kind == KIND_INSERT) ? '0 : s_data.slot;
                        off_reg    <= '0;
                        len_reg    <= '0;
                        cmp_reg    <= 1'b0;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    unique case (req_reg.kind)
                        KIND_INSERT: begin
                            if (req_reg.size == '0) begin
                                st_reg    <= ST_BAD_ARG;
                                state_reg <= S_RESP;
                            end else if (req_reg.size > MAXR_F) begin
                                st_reg    <= ST_TOO_LARGE;
                                state_reg <= S_RESP;
                            end else if (fp_reg < dir_end) begin
                                st_reg    <= ST_CORRUPT;
                                state_reg <= S_RESP;
                            end else begin
                                chunk_reg <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                        KIND_READ, KIND_DELETE: begin
                            state_reg <= S_RESP;
                            if (!found || !slot_live) begin
                                st_reg <= ST_MISSING;
                            end else if (bad_bnd) begin
                                st_reg <= ST_CORRUPT;
                            end else if (req_reg.kind == KIND_READ) begin
                                off_reg <= rd_place;
                                len_reg <= rd_bytes;
                            end else begin
                                ltot_reg <= ltot_reg - {{(LIVE_W-FLD_W){1'b0}}, rd_bytes};
                                live_reg[req_reg.slot] <= 1'b0;
                            end
                        end
                        KIND_UPDATE: begin
                            priority if (req_reg.size == '0) begin
                                st_reg    <= ST_BAD_ARG;
                                state_reg <= S_RESP;
                            end else if (!found || !slot_live) begin
                                st_reg    <= ST_MISSING;
                                state_reg <= S_RESP;
                            end else if (req_reg.size > MAXR_F) begin
                                st_reg    <= ST_TOO_LARGE;
                                state_reg <= S_RESP;
                            end else if (bad_bnd) begin
                                st_reg    <= ST_CORRUPT;
                                state_reg <= S_RESP;
                            end else if (fit_old || fit_ctg) begin
                                ltot_reg <= ltot_reg - {{(LIVE_W-FLD_W){1'b0}}, rd_bytes}
                                          + {{(LIVE_W-FLD_W){1'b0}}, req_reg.size};
                                len_reg   <= req_reg.size;
                                state_reg <= S_RESP;
                                if (fit_old) begin
                                    off_reg <= rd_place;
                                end else begin
                                    off_reg <= fp_ins;
                                    fp_reg  <= fp_ins;
                                end
                            end else if (fit_room) begin
                                // repack with the grown record in its slot
                                rep_reg    <= 1'b1;
                                cmp_reg    <= 1'b1;
                                len_reg    <= req_reg.size;
                                rd_idx_reg <= '0;
                                pend_reg   <= 1'b0;
                                ptr_reg    <= PAGE_F;
                                sum_reg    <= '0;
                                last_reg   <= '0;
                                state_reg  <= S_CMP;
                            end else begin
                                st_reg    <= ST_FULL;
                                state_reg <= S_RESP;
                            end
                        end
                        KIND_RESTORE: begin
                            state_reg <= S_RESP;
                            if (req_reg.size == '0 || !found || slot_live) begin
                                st_reg <= ST_BAD_ARG;
                            end else if (rst_bad) begin
                                st_reg <= ST_CORRUPT;
                            end else begin
                                live_reg[req_reg.slot] <= 1'b1;
                                ltot_reg <= ltot_reg + {{(LIVE_W-FLD_W){1'b0}}, req_reg.size};
                                off_reg  <= req_reg.place;
                                len_reg  <= req_reg.size;
                            end
                        end
                        KIND_COMPACT: begin
                            if (siu_reg != '0) begin
                                rep_reg    <= 1'b0;
                                cmp_reg    <= 1'b1;
                                rd_idx_reg <= '0;
                                pend_reg   <= 1'b0;
                                ptr_reg    <= PAGE_F;
                                sum_reg    <= '0;
                                last_reg   <= '0;
                                state_reg  <= S_CMP;
                            end else begin
                                state_reg <= S_RESP;
                            end
                        end
                        KIND_CLEAR: begin
                            live_reg  <= '0;
                            siu_reg   <= '0;
                            fp_reg    <= PAGE_F;
                            ltot_reg  <= '0;
                            state_reg <= S_RESP;
                        end
                        default: begin
                            st_reg    <= ST_BAD_ARG;
                            state_reg <= S_RESP;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (cand != '0) begin
                        target_reg <= {1'b0, chunk_reg, enc};
                        reuse_reg  <= 1'b1;
                        state_reg  <= S_DEC;
                    end else if (scan_end) begin
                        target_reg <= siu_reg;
                        reuse_reg  <= 1'b0;
                        state_reg  <= S_DEC;
                    end else begin
                        chunk_reg <= chunk_reg + 3'd1;
                    end
                end
                S_DEC: begin
                    if ({1'b0, contig_reg} >= need) begin
                        state_reg <= S_INS;
                    end else if (room_reg < need) begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_RESP;
                    end else begin
                        rep_reg    <= 1'b0;
                        cmp_reg    <= 1'b1;
                        rd_idx_reg <= '0;
                        pend_reg   <= 1'b0;
                        ptr_reg    <= PAGE_F;
                        sum_reg    <= '0;
                        last_reg   <= '0;
                        state_reg  <= S_CMP;
                    end
                end
                S_CMP: begin
                    // read one entry a cycle, repack the one read last cycle
                    pend_reg <= issue;
                    pidx_reg <= rd_idx_reg[SLOT_W-1:0];
                    if (issue) begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    if (pend_reg && c_live) begin
                        ptr_reg  <= c_ptr;
                        sum_reg  <= sum_reg + {{(LIVE_W-FLD_W){1'b0}}, c_len};
                        last_reg <= {1'b0, pidx_reg} + CNT_W'(1);
                        if (is_rep) begin
                            off_reg <= c_ptr;
                            live_reg[pidx_reg] <= 1'b1;
                        end
                    end
                    if (!issue && !pend_reg) begin
                        siu_reg   <= last_reg;
                        fp_reg    <= ptr_reg;
                        ltot_reg  <= sum_reg;
                        state_reg <= (req_reg.kind == KIND_INSERT) ? S_CPOST : S_RESP;
                    end
                end
                S_CPOST: begin
                    contig_reg <= contig_c;
                    if (reuse_reg && target_reg >= siu_reg) begin
                        reuse_reg  <= 1'b0;
                        target_reg <= siu_reg;
                    end
                    state_reg <= S_INS;
                end
                S_INS: begin
                    state_reg <= S_RESP;
                    if (mem_we) begin
                        fp_reg <= fp_ins;
                        live_reg[target_reg[SLOT_W-1:0]] <= 1'b1;
                        if (!reuse_reg) begin
                            siu_reg <= target_reg + CNT_W'(1);
                        end
                        ltot_reg <= ltot_reg + {{(LIVE_W-FLD_W){1'b0}}, req_reg.size};
                        sn_reg   <= target_reg[SLOT_W-1:0];
                        off_reg  <= fp_ins;
                        len_reg  <= req_reg.size;
                    end else begin
                        st_reg <= ST_FULL;
                    end
                end
                S_RESP: begin
                    // hand over once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg               <= 1'b1;
                        m_data_reg.status         <= st_reg;
                        m_data_reg.slot_number    <= sn_reg;
                        m_data_reg.payload_offset <= off_reg;
                        m_data_reg.payload_length <= len_reg;
                        m_data_reg.compacted      <= cmp_reg;
                        m_data_reg.holes_present  <= hole_now;
                        m_data_reg.free_start     <= fp_reg;
                        state_reg                 <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `SPSM_CHECK(a_fp_in_page, fp_reg <= PAGE_F, "free pointer beyond page end")
    `SPSM_CHECK(a_siu_bound, siu_reg <= CNT_W'(MAX_SLOTS), "slot count above limit")
    `SPSM_IMPLY(a_fail_zero, m_valid && m_data.status != ST_OK,
        m_data.payload_offset == '0 && m_data.payload_length == '0,
        "failed transaction reports a payload")
    `SPSM_IMPLY(a_cmp_no_holes, m_valid && m_data.compacted, !m_data.holes_present,
        "holes left after compaction")

endmodule

// File: tb/slotted_page_space_manager_tb.sv
module slotted_page_space_manager_tb;
    import spsm_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    spsm_req_t s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    spsm_rsp_t m_data;

    // page image kept alongside the block
    bit pg_live [MAX_SLOTS];
    int pg_off  [MAX_SLOTS];
    int pg_len  [MAX_SLOTS];
    int pg_slots;
    int pg_free;
    int pg_live_bytes;
    bit pg_holey;

    spsm_rsp_t rsp_expected[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    int  sink_hold = 0;

    slotted_page_space_manager u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** slotted_page_space_manager: FAILED **");
            $finish;
        end
    end

    // result receiver with random stalls and long hold-offs
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        spsm_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", m_data);
            end else begin
                want = rsp_expected.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    function automatic void page_empty();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            pg_live[i] = 1'b0;
            pg_off[i]  = 0;
            pg_len[i]  = 0;
        end
        pg_slots = 0;
        pg_free = PAGE_BYTES;
        pg_live_bytes = 0;
        pg_holey = 1'b0;
    endfunction

    function automatic int dir_end();
        return HEADER_BYTES + pg_slots * ENTRY_BYTES;
    endfunction

    function automatic int contig_bytes();
        int d;
        d = dir_end();
        return (pg_free < d) ? 0 : pg_free - d;
    endfunction

    function automatic int hole_bytes();
        int alloc;
        alloc = (pg_free > PAGE_BYTES) ? 0 : PAGE_BYTES - pg_free;
        return (alloc > pg_live_bytes) ? alloc - pg_live_bytes : 0;
    endfunction

    function automatic void refresh_holes();
        pg_holey = (hole_bytes() > 0);
    endfunction

    function automatic bit out_of_bounds(int s);
        return (pg_off[s] < pg_free) || (pg_off[s] + pg_len[s] > PAGE_BYTES);
    endfunction

    // repack live payloads from the page end in slot order
    function automatic bit repack(bit has_rep, int rslot, int rlen);
        int ptr;
        int sum;
        int last;
        ptr = PAGE_BYTES;
        sum = 0;
        last = 0;
        if (pg_slots == 0)
            return 1'b0;
        for (int i = 0; i < pg_slots && i < MAX_SLOTS; i++) begin
            if (has_rep && i == rslot) begin
                pg_live[i] = 1'b1;
                pg_len[i]  = rlen;
            end
            if (pg_live[i]) begin
                ptr = (pg_len[i] > ptr) ? 0 : ptr - pg_len[i];
                pg_off[i] = ptr;
                sum += pg_len[i];
                last = i + 1;
            end else begin
                pg_off[i] = 0;
                pg_len[i] = 0;
            end
        end
        pg_slots = last;
        pg_free = ptr;
        pg_live_bytes = sum;
        pg_holey = 1'b0;
        return 1'b1;
    endfunction

    // expected result of one request, updating the page image
    function automatic spsm_rsp_t page_outcome(spsm_req_t r);
        spsm_rsp_t o;
        int  s;
        int  sz;
        int  pl;
        int  target;
        int  need;
        int  old;
        bit  reuse;
        bit  found;
        s = r.slot;
        sz = r.size;
        pl = r.place;
        o = '0;
        o.status = ST_OK;
        o.slot_number = r.slot;
        found = (s < pg_slots);
        case (r.kind)
            KIND_INSERT: begin
                o.slot_number = '0;
                if (sz == 0) o.status = ST_BAD_ARG;
                else if (sz > MAX_RECORD) o.status = ST_TOO_LARGE;
                else if (pg_free < dir_end() || pg_free > PAGE_BYTES || pg_slots > MAX_SLOTS)
                    o.status = ST_CORRUPT;
                else begin
                    target = pg_slots;
                    reuse = 1'b0;
                    for (int i = 0; i < pg_slots; i++) begin
                        if (!pg_live[i] && !reuse) begin
                            target = i;
                            reuse = 1'b1;
                        end
                    end
                    need = sz + (reuse ? 0 : ENTRY_BYTES);
                    if (contig_bytes() < need) begin
                        if (contig_bytes() + hole_bytes() < need) o.status = ST_FULL;
                        else begin
                            void'(repack(1'b0, 0, 0));
                            o.compacted = 1'b1;
                            // the dead slot may have been pruned
                            if (reuse && target >= pg_slots) begin
                                reuse = 1'b0;
                                target = pg_slots;
                                need = sz + ENTRY_BYTES;
                            end
                            if (contig_bytes() < need) o.status = ST_FULL;
                        end
                    end
                    if (o.status == ST_OK && !reuse && pg_slots >= MAX_SLOTS)
                        o.status = ST_FULL;
                    if (o.status == ST_OK) begin
                        pg_free -= sz;
                        pg_live[target] = 1'b1;
                        pg_off[target] = pg_free;
                        pg_len[target] = sz;
                        if (!reuse) pg_slots = target + 1;
                        pg_live_bytes += sz;
                        refresh_holes();
                        o.slot_number = target;
                        o.payload_offset = pg_free;
                        o.payload_length = sz;
                    end
                end
            end
            KIND_READ: begin
                if (!found || !pg_live[s]) o.status = ST_MISSING;
                else if (out_of_bounds(s)) o.status = ST_CORRUPT;
                else begin
                    o.payload_offset = pg_off[s];
                    o.payload_length = pg_len[s];
                end
            end
            KIND_UPDATE: begin
                if (sz == 0) o.status = ST_BAD_ARG;
                else if (!found || !pg_live[s]) o.status = ST_MISSING;
                else if (sz > MAX_RECORD) o.status = ST_TOO_LARGE;
                else if (out_of_bounds(s)) o.status = ST_CORRUPT;
                else begin
                    old = pg_len[s];
                    if (sz <= old) begin
                        pg_len[s] = sz;
                        pg_live_bytes -= old - sz;
                        refresh_holes();
                    end else if (sz <= contig_bytes()) begin
                        pg_free -= sz;
                        pg_off[s] = pg_free;
                        pg_len[s] = sz;
                        pg_live_bytes += sz - old;
                        refresh_holes();
                    end else if (sz - old <= contig_bytes() + hole_bytes()) begin
                        void'(repack(1'b1, s, sz));
                        o.compacted = 1'b1;
                    end else o.status = ST_FULL;
                    if (o.status == ST_OK) begin
                        o.payload_offset = pg_off[s];
                        o.payload_length = pg_len[s];
                    end
                end
            end
            KIND_DELETE: begin
                if (!found || !pg_live[s]) o.status = ST_MISSING;
                else if (out_of_bounds(s)) o.status = ST_CORRUPT;
                else begin
                    pg_live_bytes -= pg_len[s];
                    pg_live[s] = 1'b0;
                    pg_off[s] = 0;
                    pg_len[s] = 0;
                    refresh_holes();
                end
            end
            KIND_RESTORE: begin
                if (sz == 0 || !found || pg_live[s]) o.status = ST_BAD_ARG;
                else if (pl < pg_free || pl + sz > PAGE_BYTES) o.status = ST_CORRUPT;
                else begin
                    pg_live[s] = 1'b1;
                    pg_off[s] = pl;
                    pg_len[s] = sz;
                    pg_live_bytes += sz;
                    refresh_holes();
                    o.payload_offset = pl;
                    o.payload_length = sz;
                end
            end
            KIND_COMPACT: o.compacted = repack(1'b0, 0, 0);
            KIND_CLEAR:   page_empty();
            default:      o.status = ST_BAD_ARG;
        endcase
        o.holes_present = pg_holey;
        o.free_start = pg_free;
        return o;
    endfunction

    // offer one request and record its expected result once accepted
    task automatic send_req(input logic [2:0] kind, input int slot, input int size,
                            input int place);
        spsm_req_t r;
        int gap;
        r.kind = kind;
        r.slot = slot;
        r.size = size;
        r.place = place;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        rsp_expected = {rsp_expected, page_outcome(r)};
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (rsp_expected.size() != 0) @(posedge aclk);
    endtask

    function automatic int rand_size();
        int p;
        p = $urandom_range(99);
        if (p < 3) return 0;
        if (p < 75) return $urandom_range(64, 1);
        if (p < 95) return $urandom_range(MAX_RECORD, 65);
        return $urandom_range(PAGE_BYTES, MAX_RECORD + 1);
    endfunction

    function automatic int rand_slot();
        if (pg_slots > 0 && $urandom_range(99) < 85) return $urandom_range(pg_slots - 1);
        return $urandom_range(255);
    endfunction

    // one random request, mostly well formed against the current page
    task automatic send_random();
        int p;
        int sz;
        int s;
        int pl;
        p = $urandom_range(99);
        sz = rand_size();
        s = rand_slot();
        pl = $urandom_range(PAGE_BYTES);
        if (p < 40) send_req(KIND_INSERT, s, sz, pl);
        else if (p < 55) send_req(KIND_READ, s, sz, pl);
        else if (p < 67) send_req(KIND_UPDATE, s, sz, pl);
        else if (p < 81) send_req(KIND_DELETE, s, sz, pl);
        else if (p < 94) begin
            // aim a restore at a dead slot inside the allocated area
            for (int i = 0; i < pg_slots; i++)
                if (!pg_live[i] && $urandom_range(1)) s = i;
            if (sz > 0 && pg_free + sz <= PAGE_BYTES && $urandom_range(99) < 80)
                pl = $urandom_range(PAGE_BYTES - sz, pg_free);
            send_req(KIND_RESTORE, s, sz, pl);
        end
        else if (p < 97) send_req(KIND_COMPACT, s, sz, pl);
        else if (p < 98) send_req(KIND_CLEAR, s, sz, pl);
        else if (p < 99) send_req(KIND_UNUSED, s, sz, pl);
        else send_req(KIND_INSERT, s, $urandom_range(8, 1), pl);
    endtask

    // status codes, shrink, compaction on insert and on update
    task automatic test_directed();
        send_req(KIND_COMPACT, 0, 0, 0);
        send_req(KIND_INSERT, 0, 0, 0);
        send_req(KIND_INSERT, 0, MAX_RECORD + 1, 0);
        send_req(KIND_INSERT, 255, PAGE_BYTES, 8191);
        send_req(KIND_READ, 0, 0, 0);
        send_req(KIND_INSERT, 0, MAX_RECORD, 0);
        send_req(KIND_INSERT, 0, 1000, 0);
        send_req(KIND_INSERT, 0, 1000, 0);
        send_req(KIND_INSERT, 0, 10, 0);
        send_req(KIND_READ, 0, 0, 0);
        send_req(KIND_UPDATE, 1, 0, 0);
        send_req(KIND_UPDATE, 255, 10, 0);
        send_req(KIND_UPDATE, 0, MAX_RECORD + 1, 0);
        send_req(KIND_UPDATE, 1, 500, 0);
        send_req(KIND_DELETE, 2, 0, 0);
        send_req(KIND_INSERT, 0, 600, 0);
        send_req(KIND_UPDATE, 1, 1000, 0);
        send_req(KIND_UPDATE, 2, MAX_RECORD, 0);
        send_req(KIND_DELETE, 0, 0, 0);
        send_req(KIND_DELETE, 0, 0, 0);
        send_req(KIND_RESTORE, 1, 10, 4000);
        send_req(KIND_RESTORE, 0, 10, 0);
        send_req(KIND_RESTORE, 0, MAX_RECORD, pg_free);
        send_req(KIND_UNUSED, 170, 4096, 4096);
        send_req(KIND_CLEAR, 0, 0, 0);
        stop_sending();
    endtask

    // overlapping restores push live bytes past the allocated area
    task automatic test_overlap();
        send_req(KIND_INSERT, 0, 1500, 0);
        send_req(KIND_INSERT, 0, 1500, 0);
        send_req(KIND_DELETE, 0, 0, 0);
        send_req(KIND_DELETE, 1, 0, 0);
        send_req(KIND_RESTORE, 0, MAX_RECORD, 1096);
        send_req(KIND_RESTORE, 1, MAX_RECORD, 1096);
        send_req(KIND_INSERT, 0, 100, 0);
        send_req(KIND_COMPACT, 0, 0, 0);
        send_req(KIND_INSERT, 0, 1, 0);
        send_req(KIND_CLEAR, 0, 0, 0);
        stop_sending();
    endtask

    task automatic test_random(input int n, input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n) send_random();
        stop_sending();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold = 400;
        repeat (30) send_random();
        stop_sending();
    endtask

    // sender pauses until the block has answered everything
    task automatic test_drain_pause();
        repeat (20) send_random();
        stop_sending();
        wait_drained();
        repeat (20) send_random();
        stop_sending();
    endtask

    initial begin
        page_empty();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 6;
        sink_idle_pct = 64;
        test_directed();
        test_overlap();
        test_random(620, 6, 64);
        test_random(620, 64, 6);
        test_backpressure();
        test_drain_pause();
        test_random(620, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && rsp_expected.size() == 0) begin
            $display("** slotted_page_space_manager: PASSED **");
        end else begin
            $display("** slotted_page_space_manager: FAILED **");
        end
        $finish;
    end

endmodule
